FILE: hw/rtl/slt_pkg.sv
`default_nettype none

package slt_pkg;

  // Request codes
  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_FIND   = 3'd1,
    OP_GET    = 3'd2,
    OP_UPDATE = 3'd3,
    OP_DELETE = 3'd4,
    OP_CLEAR  = 3'd5
  } slt_op_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_BAD_POS   = 2'd3
  } slt_status_t;

  // Input beat
  typedef struct packed {
    slt_op_t            req_type;
    logic signed [31:0] key;
    logic        [3:0]  position;
  } slt_req_t;

  // Result beat
  typedef struct packed {
    slt_status_t        status;
    logic        [3:0]  found_position;
    logic signed [31:0] read_value;
    logic        [4:0]  entry_count;
  } slt_rsp_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    logic cmp_en;   // latch compare flags against the incoming key
    logic do_ins;   // insert: shift up and drop the key into the gap
    logic do_upd;   // overwrite the selected entry
    logic do_del;   // shift down over the selected entry
  } slt_cell_ctrl_t;

  // Per-cell status, partly chained to the neighbors
  typedef struct packed {
    logic suf;      // some valid entry at or above this cell is <= key
    logic scan;     // find scan has stopped at or below this cell
    logic hit;      // find scan stops here and the entry equals the key
    logic lt_last;  // this is the last valid entry and it is below the key
    logic above;    // entry is greater than the key
  } slt_cell_stat_t;

endpackage

`default_nettype wire

FILE: hw/rtl/slt_cell.sv
`default_nettype none

module slt_cell #(
  parameter int IDX       = 0,
  parameter int KEY_WIDTH = 32,
  parameter int CNT_W     = 5,
  parameter int IDX_W     = 4
) (
  input  wire                            clk,
  input  slt_pkg::slt_cell_ctrl_t        ctrl,
  input  wire  [CNT_W-1:0]               count,
  input  wire  [3:0]                     position,
  input  wire  [KEY_WIDTH-1:0]           cmp_key,
  input  wire  [KEY_WIDTH-1:0]           wr_key,
  input  wire  [KEY_WIDTH-1:0]           left_val,
  input  wire  [KEY_WIDTH-1:0]           right_val,
  input  wire                            left_suf,
  input  wire                            right_suf,
  input  wire                            left_scan,
  output logic [KEY_WIDTH-1:0]           val,
  output slt_pkg::slt_cell_stat_t        stat,
  output logic [IDX_W-1:0]               fpos,
  output logic [KEY_WIDTH-1:0]           rdv
);

  logic [KEY_WIDTH-1:0] val_r, val_nxt;
  logic                 lt_r, eq_r;
  logic                 valid, last, stop, sel, stop_cond;

  // Position of this cell relative to the list
  assign valid     = (IDX < int'(count));
  assign last      = (IDX == int'(count) - 1);
  assign sel       = (IDX == int'(position));
  assign stop_cond = valid & (~lt_r | last);
  assign stop      = ~left_scan & stop_cond;

  // Status toward the neighbors and the controller
  always_comb begin
    stat.suf     = right_suf | (valid & (lt_r | eq_r));
    stat.scan    = left_scan | stop_cond;
    stat.hit     = stop & eq_r;
    stat.lt_last = last & lt_r;
    stat.above   = ~lt_r & ~eq_r;
  end

  assign fpos = stop ? IDX_W'(IDX) : '0;
  assign rdv  = sel ? val_r : '0;
  assign val  = val_r;

  // Entry update: shift from a neighbor, take the key, or hold
  always_comb begin
    val_nxt = val_r;
    if (ctrl.do_ins && (IDX <= int'(count))) begin
      if (!left_suf) begin
        val_nxt = left_val;
      end else if (!stat.suf) begin
        val_nxt = wr_key;
      end
    end
    if (ctrl.do_upd && sel) begin
      val_nxt = wr_key;
    end
    if (ctrl.do_del && (IDX >= int'(position)) && (IDX + 1 < int'(count))) begin
      val_nxt = right_val;
    end
  end

  // Entry and compare flags (payload, no reset)
  always_ff @(posedge clk) begin
    val_r <= val_nxt;
    if (ctrl.cmp_en) begin
      lt_r <= ($signed(val_r) < $signed(cmp_key));
      eq_r <= (val_r == cmp_key);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sorted_list_table_top.sv
`default_nettype none
// Channel  Ports                       Beat
// in       in_valid/in_ready/in_data   slt_req_t: req_type, key, position
// out      out_valid/out_ready/out_data slt_rsp_t: status, found_position,
//                                       read_value, entry_count
//
// Each request has an accept cycle and a commit cycle: the accept cycle
// latches compare flags in every cell of the chain, the commit cycle
// resolves the neighbor chains and commits the entries, count and the
// result register. A new request is taken once the previous one has moved
// into the result register, so no request overlaps the previous one.
// Reset (rst_n low, synchronous) empties the list, drops any pending request
// and clears out_valid.
// A stalled result holds back the commit until out_ready frees the register.

module sorted_list_table_top #(
  parameter int CAPACITY  = 16,
  parameter int KEY_WIDTH = 32
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_ready,
  input  slt_pkg::slt_req_t  in_data,
  output logic               out_valid,
  input  wire                out_ready,
  output slt_pkg::slt_rsp_t  out_data
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int PW    = (CNT_W > 4) ? CNT_W : 4;

  logic                      busy_r, busy_nxt;
  logic                      out_valid_r, out_valid_nxt;
  slt_pkg::slt_req_t         req_r;
  slt_pkg::slt_rsp_t         out_data_r, out_data_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic                      accept, exec, full, pos_ok;
  logic signed [63:0]        in_key64, req_key64;
  logic [KEY_WIDTH-1:0]      cmp_key, wr_key;
  slt_pkg::slt_cell_ctrl_t   ctrl;

  logic [KEY_WIDTH-1:0]      val_w  [CAPACITY];
  slt_pkg::slt_cell_stat_t   stat_w [CAPACITY];
  logic [IDX_W-1:0]          fpos_w [CAPACITY];
  logic [KEY_WIDTH-1:0]      rdv_w  [CAPACITY];

  logic                      hit, lt_last;
  logic [IDX_W-1:0]          fpos;
  logic [KEY_WIDTH-1:0]      rdv;
  logic [63:0]               rdv64;

  // Handshake
  assign in_ready  = ~busy_r;
  assign accept    = in_valid & in_ready;
  assign exec      = busy_r & (~out_valid_r | out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Keys resized to the stored width
  assign in_key64  = 64'(in_data.key);
  assign req_key64 = 64'(req_r.key);
  assign cmp_key   = in_key64[KEY_WIDTH-1:0];
  assign wr_key    = req_key64[KEY_WIDTH-1:0];

  assign full   = (count_r == CNT_W'(CAPACITY));
  assign pos_ok = (PW'(req_r.position) < PW'(count_r));

  // Cell controls
  always_comb begin
    ctrl.cmp_en = accept;
    ctrl.do_ins = exec & (req_r.req_type == slt_pkg::OP_INSERT) & ~full;
    ctrl.do_upd = exec & (req_r.req_type == slt_pkg::OP_UPDATE) & pos_ok;
    ctrl.do_del = exec & (req_r.req_type == slt_pkg::OP_DELETE) & pos_ok;
  end

  // Chain of entry cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0] lv, rv;
    logic                 lsuf, rsuf, lscan;

    if (i == 0) begin : g_first
      assign lv    = '0;
      assign lsuf  = 1'b1;
      assign lscan = 1'b0;
    end else begin : g_mid
      assign lv    = val_w[i-1];
      assign lsuf  = stat_w[i-1].suf;
      assign lscan = stat_w[i-1].scan;
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rv   = '0;
      assign rsuf = 1'b0;
    end else begin : g_inner
      assign rv   = val_w[i+1];
      assign rsuf = stat_w[i+1].suf;
    end

    slt_cell #(
      .IDX       (i),
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W),
      .IDX_W     (IDX_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count_r),
      .position  (req_r.position),
      .cmp_key   (cmp_key),
      .wr_key    (wr_key),
      .left_val  (lv),
      .right_val (rv),
      .left_suf  (lsuf),
      .right_suf (rsuf),
      .left_scan (lscan),
      .val       (val_w[i]),
      .stat      (stat_w[i]),
      .fpos      (fpos_w[i]),
      .rdv       (rdv_w[i])
    );
  end

  // Gather cell outputs
  always_comb begin
    hit     = 1'b0;
    lt_last = 1'b0;
    fpos    = '0;
    rdv     = '0;
    for (int j = 0; j < CAPACITY; j++) begin
      hit     = hit | stat_w[j].hit;
      lt_last = lt_last | stat_w[j].lt_last;
      fpos    = fpos | fpos_w[j];
      rdv     = rdv | rdv_w[j];
    end
  end

  assign rdv64 = 64'(rdv);

  // Result and next count
  always_comb begin
    count_nxt                   = count_r;
    out_data_nxt.status         = slt_pkg::ST_OK;
    out_data_nxt.found_position = '0;
    out_data_nxt.read_value     = '0;
    case (req_r.req_type)
      slt_pkg::OP_INSERT: begin
        if (full) begin
          out_data_nxt.status = slt_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      slt_pkg::OP_FIND: begin
        if ((count_r == '0) || stat_w[0].above || lt_last || !hit) begin
          out_data_nxt.status = slt_pkg::ST_NOT_FOUND;
        end else begin
          out_data_nxt.found_position = 4'(fpos);
        end
      end
      slt_pkg::OP_GET: begin
        if (!pos_ok) begin
          out_data_nxt.status = slt_pkg::ST_BAD_POS;
        end else begin
          out_data_nxt.read_value = rdv64[31:0];
        end
      end
      slt_pkg::OP_UPDATE: begin
        if (!pos_ok) begin
          out_data_nxt.status = slt_pkg::ST_BAD_POS;
        end
      end
      slt_pkg::OP_DELETE: begin
        if (!pos_ok) begin
          out_data_nxt.status = slt_pkg::ST_BAD_POS;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      slt_pkg::OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
      end
    endcase
    out_data_nxt.entry_count = 5'(count_nxt);
  end

  // Control next state
  always_comb begin
    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (exec) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
    end
    if (accept) begin
      busy_nxt = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      if (exec) begin
        count_r <= count_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    if (exec) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_exec_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    exec |=> out_valid_r)
    else $error("executed request left no result");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy_r && !in_ready))
    else $error("accepted request not held");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.do_ins |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("insert did not grow the list");

  a_find_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (exec && (req_r.req_type == slt_pkg::OP_FIND) &&
     (out_data_nxt.status == slt_pkg::ST_OK)) |-> (PW'(fpos) < PW'(count_r)))
    else $error("find position outside the list");

endmodule

`default_nettype wire

FILE: test/tb_sorted_list_table_top.sv
`default_nettype none

module tb_sorted_list_table_top;

  localparam int LIST_CAP = 16;

  // Request codes outside the defined set: the block must treat them as no-ops
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  logic               clk       = 1'b0;
  logic               rst_n     = 1'b0;
  logic               in_valid  = 1'b0;
  slt_pkg::slt_req_t  in_data   = '0;
  logic               out_ready = 1'b0;
  wire                in_ready;
  wire                out_valid;
  slt_pkg::slt_rsp_t  out_data;

  sorted_list_table_top #(
    .CAPACITY (LIST_CAP),
    .KEY_WIDTH(32)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the list, updated as each request beat is accepted
  logic signed [31:0] list_keys [LIST_CAP];
  int                 list_count = 0;
  slt_pkg::slt_rsp_t  expected_rsp_q[$];
  int                 err_count  = 0;
  bit                 idle_en    = 1'b1;
  int                 stall_left = 0;

  // Apply one request to the shadow list and return the response it produces
  function automatic slt_pkg::slt_rsp_t apply_request(slt_pkg::slt_req_t r);
    slt_pkg::slt_rsp_t  rsp;
    logic signed [31:0] k;
    int                 i;
    rsp = '0;
    rsp.status = slt_pkg::ST_OK;
    k = r.key;
    case (r.req_type)
      slt_pkg::OP_INSERT: begin
        if (list_count >= LIST_CAP) begin
          rsp.status = slt_pkg::ST_FULL;
        end else if (list_count == 0 || k > list_keys[list_count-1]) begin
          list_keys[list_count] = k;
          list_count++;
        end else begin
          // shift up from the end while entries are above the key
          i = list_count;
          while (i > 0 && k < list_keys[i-1]) begin
            list_keys[i] = list_keys[i-1];
            i--;
          end
          list_keys[i] = k;
          list_count++;
        end
      end
      slt_pkg::OP_FIND: begin
        if (list_count == 0 || k < list_keys[0] || k > list_keys[list_count-1]) begin
          rsp.status = slt_pkg::ST_NOT_FOUND;
        end else begin
          // scan stops at the first entry not below the key, or the last one
          i = 0;
          while (i < list_count - 1 && list_keys[i] < k) i++;
          if (list_keys[i] == k) rsp.found_position = i[3:0];
          else rsp.status = slt_pkg::ST_NOT_FOUND;
        end
      end
      slt_pkg::OP_GET: begin
        if (int'(r.position) >= list_count) rsp.status = slt_pkg::ST_BAD_POS;
        else rsp.read_value = list_keys[r.position];
      end
      slt_pkg::OP_UPDATE: begin
        if (int'(r.position) >= list_count) rsp.status = slt_pkg::ST_BAD_POS;
        else list_keys[r.position] = k;
      end
      slt_pkg::OP_DELETE: begin
        if (int'(r.position) >= list_count) begin
          rsp.status = slt_pkg::ST_BAD_POS;
        end else begin
          for (i = int'(r.position); i + 1 < list_count; i++) list_keys[i] = list_keys[i+1];
          list_count--;
        end
      end
      slt_pkg::OP_CLEAR: list_count = 0;
      default: ;
    endcase
    rsp.entry_count = list_count[4:0];
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("mismatch @%0t: %s", $time, msg);
  endtask

  // Result checker and request predictor, both on the rising edge
  always @(posedge clk) begin : check_results
    slt_pkg::slt_rsp_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("result beat with no request outstanding");
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
          if (out_data.found_position !== want.found_position)
            report_mismatch($sformatf("found_position %0d, want %0d",
                                      out_data.found_position, want.found_position));
          if (out_data.read_value !== want.read_value)
            report_mismatch($sformatf("read_value %0d, want %0d",
                                      out_data.read_value, want.read_value));
          if (out_data.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count %0d, want %0d",
                                      out_data.entry_count, want.entry_count));
        end
      end
      if (in_valid && in_ready) expected_rsp_q.push_back(apply_request(in_data));
    end
  end

  // Result side back-pressure: random stall bursts
  always @(negedge clk) begin
    if (!idle_en) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 4) == 0) begin
      out_ready  <= 1'b0;
      stall_left = $urandom_range(0, 12);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Drive one request beat, with an optional idle burst ahead of it
  task automatic send_request(input logic [2:0] op, input logic signed [31:0] k_val,
                              input logic [3:0] pos);
    int gap;
    gap = 0;
    if (idle_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 13);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{req_type: slt_pkg::slt_op_t'(op), key: k_val, position: pos};
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Keys: small pool for duplicates, extremes, neighbors of stored keys, or anything
  function automatic logic signed [31:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel <= 3) return int'($urandom_range(0, 16)) - 8;
    if (sel == 4) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return -1;
        default: return 0;
      endcase
    end
    if (sel <= 6 && list_count > 0)
      return list_keys[$urandom_range(0, list_count - 1)] + (int'($urandom_range(0, 2)) - 1);
    return $urandom;
  endfunction

  function automatic logic [3:0] pick_position();
    if (list_count > 0 && $urandom_range(0, 1) == 0)
      return 4'($urandom_range(0, list_count - 1));
    return 4'($urandom_range(0, 15));
  endfunction

  task automatic test_empty_list();
    send_request(slt_pkg::OP_FIND,   32'sd5, 4'd0);
    send_request(slt_pkg::OP_GET,    32'sd0, 4'd0);
    send_request(slt_pkg::OP_UPDATE, 32'sd9, 4'd3);
    send_request(slt_pkg::OP_DELETE, 32'sd0, 4'd0);
    send_request(slt_pkg::OP_CLEAR,  32'sd0, 4'd0);
  endtask

  task automatic test_order_and_find();
    send_request(slt_pkg::OP_INSERT, 32'sd0,   4'd0);
    send_request(slt_pkg::OP_INSERT, 32'sd100, 4'd0);
    // below the first, above the last, and a gap inside the range
    send_request(slt_pkg::OP_FIND,   -32'sd1,  4'd0);
    send_request(slt_pkg::OP_FIND,   32'sd200, 4'd0);
    send_request(slt_pkg::OP_FIND,   32'sd50,  4'd0);
    send_request(slt_pkg::OP_INSERT, KEY_MAX,  4'd0);
    send_request(slt_pkg::OP_INSERT, KEY_MIN,  4'd0);
    // equal key goes after the existing one; find reports the first
    send_request(slt_pkg::OP_INSERT, 32'sd0,   4'd0);
    send_request(slt_pkg::OP_FIND,   32'sd0,   4'd0);
    send_request(slt_pkg::OP_FIND,   KEY_MIN,  4'd0);
    send_request(slt_pkg::OP_GET,    32'sd0,   4'd4);
    send_request(slt_pkg::OP_GET,    32'sd0,   4'd15);
  endtask

  task automatic test_unsorted_update();
    // overwrite breaks the order; find and insert must follow the plain scans
    send_request(slt_pkg::OP_UPDATE, KEY_MAX, 4'd1);
    send_request(slt_pkg::OP_FIND,   32'sd0,  4'd0);
    send_request(slt_pkg::OP_INSERT, 32'sd50, 4'd0);
  endtask

  task automatic test_misc_requests();
    send_request(slt_pkg::OP_DELETE, 32'sd0, 4'd0);
    send_request(slt_pkg::OP_DELETE, 32'sd0, 4'd15);
    send_request(OP_RSVD_6, KEY_MAX, 4'd2);
    send_request(OP_RSVD_7, KEY_MIN, 4'd1);
    send_request(slt_pkg::OP_CLEAR,  32'sd0, 4'd0);
  endtask

  // Random mix; insert and delete weights steer the fill level
  task automatic test_random_phase(input int n, input int ins_w, input int del_w,
                                   input bit idle);
    int         r;
    logic [2:0] op;
    idle_en = idle;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < ins_w) op = slt_pkg::OP_INSERT;
      else if (r < ins_w + del_w) op = slt_pkg::OP_DELETE;
      else if (r >= 97) op = slt_pkg::OP_CLEAR;
      else if (r >= 95) op = $urandom_range(0, 1) ? OP_RSVD_6 : OP_RSVD_7;
      else begin
        case ($urandom_range(0, 2))
          0: op = slt_pkg::OP_FIND;
          1: op = slt_pkg::OP_GET;
          default: op = slt_pkg::OP_UPDATE;
        endcase
      end
      send_request(op, pick_key(), pick_position());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    test_empty_list();
    test_order_and_find();
    test_unsorted_update();
    test_misc_requests();

    test_random_phase(150, 35, 20, 1'b1);
    test_random_phase(150, 80, 5,  1'b1);   // fill up and hit the full list
    test_random_phase(150, 10, 60, 1'b1);   // drain
    test_random_phase(150, 35, 20, 1'b0);
    test_random_phase(150, 70, 10, 1'b1);
    test_random_phase(150, 35, 25, 1'b1);
    test_random_phase(150, 40, 20, 1'b0);

    @(negedge clk) in_valid <= 1'b0;
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

endmodule

`default_nettype wire
